>>> hw/rtl/uars_pkg.sv
`default_nettype none
package uars_pkg;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_TIMEOUT  = 2'd1,
        KIND_RESPONSE = 2'd2,
        KIND_BEACON   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_POLL   = 3'd0,
        ACT_LISTEN = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_REPORT = 3'd3,
        ACT_DONE   = 3'd4,
        ACT_LIST   = 3'd5
    } t_action;

    localparam logic [2:0] CFG_RANGING_EN  = 3'd0;
    localparam logic [2:0] CFG_REPORT_EN   = 3'd1;
    localparam logic [2:0] CFG_BEACON_PER  = 3'd2;
    localparam logic [2:0] CFG_RETRY_LIMIT = 3'd3;
    localparam logic [2:0] CFG_EVICT_THR   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // result buffer: at most four items per input item
    localparam int RES_IDX_W = 2;
    localparam int RES_CNT_W = 3;
    localparam int RES_DEPTH = 4;

    localparam logic [2:0] MISS_MAX  = 3'd7;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_IDX_CLR,
        OP_STOP_PUSH,
        OP_LISTEN_CLR,
        OP_RETRY,
        OP_FAIL,
        OP_RESP,
        OP_SCAN_STEP,
        OP_SCAN_HIT,
        OP_SCAN_EMPTY,
        OP_SCAN_END,
        OP_ROUND_END,
        OP_BCN_UPDATE,
        OP_BCN_INSERT,
        OP_EMIT_NEXT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  ranging_en;
        logic  listening;
        logic  retry_lt;
        logic  idx_end;
        logic  occupied;
        logic  match;
        logic  src_zero;
        logic  res_empty;
        logic  rd_last;
    } t_dp_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TMO,
        S_RESP,
        S_SCAN,
        S_ROUND,
        S_BMATCH,
        S_BFREE,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/uars_dp.sv
`default_nettype none
module uars_dp #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire uars_pkg::t_dp_cmd              i_cmd,
    output uars_pkg::t_dp_status                o_status,
    input  wire logic                           i_cfg_we,
    input  wire logic [uars_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [uars_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [1:0]                     i_kind,
    input  wire logic                           i_success,
    input  wire logic [15:0]                    i_src_addr,
    input  wire logic [15:0]                    i_distance,
    input  wire logic [7:0]                     i_rx_quality,
    input  wire logic [15:0]                    i_nhop_addr,
    input  wire logic [7:0]                     i_nhop_cnt,
    output uars_pkg::t_action                   o_action,
    output logic [15:0]                         o_target_address,
    output logic [15:0]                         o_range_value,
    output logic [7:0]                          o_quality,
    output logic [3:0]                          o_anchor_total,
    output logic                                o_last
);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(NUM_SLOTS);

    // configuration
    logic       r_ranging_en;
    logic       r_report_en;
    logic [7:0] r_beacon_per;
    logic [2:0] r_retry_limit;
    logic [2:0] r_evict_thr;

    // table
    logic [15:0] r_anchor [NUM_SLOTS];
    logic [2:0]  r_miss   [NUM_SLOTS];
    logic [15:0] r_next_hop [NUM_SLOTS];
    logic [7:0]  r_hops   [NUM_SLOTS];

    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cur;
    logic [2:0]       r_retry;
    logic             r_listening;
    logic [7:0]       r_countdown;
    logic [3:0]       r_count;

    // latched input item
    uars_pkg::t_kind r_kind;
    logic        r_ok;
    logic [15:0] r_src;
    logic [15:0] r_dist;
    logic [7:0]  r_rxq;
    logic [15:0] r_hop_addr;
    logic [7:0]  r_hop_cnt;

    // result buffer
    uars_pkg::t_action r_res_act [uars_pkg::RES_DEPTH];
    logic [15:0] r_res_addr [uars_pkg::RES_DEPTH];
    logic [15:0] r_res_rng  [uars_pkg::RES_DEPTH];
    logic [7:0]  r_res_q    [uars_pkg::RES_DEPTH];
    logic [uars_pkg::RES_CNT_W-1:0] r_res_cnt;
    logic [uars_pkg::RES_IDX_W-1:0] r_res_rd;

    logic [SLOT_W-1:0] w_sel;
    logic              w_idx_end;
    logic [15:0]       w_slot_addr;
    logic [2:0]        w_slot_miss;
    logic [2:0]        w_miss_inc;
    logic              w_evict;
    logic [CNT_W-1:0]  w_resp_start;
    logic [7:0]        w_reload;
    logic              w_push;
    uars_pkg::t_action w_push_act;
    logic [15:0]       w_push_addr;
    logic [15:0]       w_push_rng;
    logic [7:0]        w_push_q;
    logic              w_rd_last;

    assign w_sel       = r_idx[SLOT_W-1:0];
    assign w_idx_end   = (r_idx >= SLOT_END);
    assign w_slot_addr = w_idx_end ? 16'd0 : r_anchor[w_sel];
    assign w_slot_miss = w_idx_end ? 3'd0 : r_miss[w_sel];
    assign w_miss_inc  = (w_slot_miss < uars_pkg::MISS_MAX) ? w_slot_miss + 3'd1 : w_slot_miss;
    assign w_evict     = !r_ok && !w_idx_end && (w_miss_inc > r_evict_thr)
                         && (w_slot_addr != 16'd0);
    assign w_resp_start = w_idx_end ? SLOT_END : r_idx + CNT_W'(1);
    assign w_reload    = (r_beacon_per == 8'd0) ? 8'd0 : r_beacon_per - 8'd1;
    assign w_rd_last   = ({1'b0, r_res_rd} == r_res_cnt - uars_pkg::RES_CNT_W'(1));

    always_comb begin
        o_status.kind       = r_kind;
        o_status.ranging_en = r_ranging_en;
        o_status.listening  = r_listening;
        o_status.retry_lt   = (r_retry < r_retry_limit);
        o_status.idx_end    = w_idx_end;
        o_status.occupied   = (w_slot_addr != 16'd0);
        o_status.match      = (w_slot_addr == r_src);
        o_status.src_zero   = (r_src == 16'd0);
        o_status.res_empty  = (r_res_cnt == '0);
        o_status.rd_last    = w_rd_last;
    end

    always_comb begin
        w_push      = 1'b0;
        w_push_act  = uars_pkg::ACT_POLL;
        w_push_addr = 16'd0;
        w_push_rng  = 16'd0;
        w_push_q    = 8'd0;
        unique case (i_cmd.op)
            uars_pkg::OP_STOP_PUSH: begin
                w_push     = 1'b1;
                w_push_act = uars_pkg::ACT_STOP;
            end
            uars_pkg::OP_RETRY, uars_pkg::OP_SCAN_HIT: begin
                w_push      = 1'b1;
                w_push_act  = uars_pkg::ACT_POLL;
                w_push_addr = w_slot_addr;
            end
            uars_pkg::OP_RESP: begin
                if (w_evict) begin
                    w_push     = 1'b1;
                    w_push_act = uars_pkg::ACT_LIST;
                end else if (r_ok && r_report_en) begin
                    w_push      = 1'b1;
                    w_push_act  = uars_pkg::ACT_REPORT;
                    w_push_addr = r_src;
                    w_push_rng  = r_dist;
                    w_push_q    = r_rxq;
                end
            end
            uars_pkg::OP_SCAN_EMPTY: begin
                w_push     = 1'b1;
                w_push_act = uars_pkg::ACT_LISTEN;
            end
            uars_pkg::OP_SCAN_END: begin
                w_push     = 1'b1;
                w_push_act = uars_pkg::ACT_DONE;
            end
            uars_pkg::OP_ROUND_END: begin
                w_push     = 1'b1;
                w_push_act = (r_countdown == 8'd0) ? uars_pkg::ACT_LISTEN
                                                   : uars_pkg::ACT_STOP;
            end
            uars_pkg::OP_BCN_INSERT: begin
                w_push     = 1'b1;
                w_push_act = uars_pkg::ACT_LIST;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranging_en  <= 1'b0;
            r_report_en   <= 1'b1;
            r_beacon_per  <= 8'd4;
            r_retry_limit <= 3'd4;
            r_evict_thr   <= 3'd3;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_anchor[i]   <= 16'd0;
                r_miss[i]     <= 3'd0;
                r_next_hop[i] <= 16'd0;
                r_hops[i]     <= 8'd0;
            end
            r_idx       <= '0;
            r_cur       <= '0;
            r_retry     <= 3'd0;
            r_listening <= 1'b0;
            r_countdown <= 8'd3;
            r_count     <= 4'd0;
            r_res_cnt   <= '0;
            r_res_rd    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    uars_pkg::CFG_RANGING_EN:  r_ranging_en  <= i_cfg_wdata[0];
                    uars_pkg::CFG_REPORT_EN:   r_report_en   <= i_cfg_wdata[0];
                    uars_pkg::CFG_BEACON_PER:  r_beacon_per  <= i_cfg_wdata;
                    uars_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata[2:0];
                    uars_pkg::CFG_EVICT_THR:   r_evict_thr   <= i_cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end
            if (w_push) begin
                r_res_cnt <= r_res_cnt + uars_pkg::RES_CNT_W'(1);
            end
            unique case (i_cmd.op)
                uars_pkg::OP_LOAD: begin
                    // table walks for timeouts and responses start at the current slot
                    r_idx     <= r_cur;
                    r_res_cnt <= '0;
                    r_res_rd  <= '0;
                end
                uars_pkg::OP_IDX_CLR:    r_idx <= '0;
                uars_pkg::OP_LISTEN_CLR: r_listening <= 1'b0;
                uars_pkg::OP_RETRY:      r_retry <= r_retry + 3'd1;
                uars_pkg::OP_FAIL:       r_retry <= 3'd0;
                uars_pkg::OP_RESP: begin
                    if (!w_idx_end) begin
                        if (!r_ok) begin
                            r_miss[w_sel] <= w_miss_inc;
                        end else begin
                            r_miss[w_sel] <= 3'd0;
                        end
                    end
                    if (w_evict) begin
                        r_anchor[w_sel] <= 16'd0;
                        if (r_count != 4'd0) begin
                            r_count <= r_count - 4'd1;
                        end
                    end
                    r_idx <= w_resp_start;
                end
                uars_pkg::OP_SCAN_STEP: r_idx <= r_idx + CNT_W'(1);
                uars_pkg::OP_SCAN_HIT:  r_cur <= r_idx;
                uars_pkg::OP_SCAN_EMPTY: begin
                    r_cur       <= r_idx;
                    r_listening <= 1'b1;
                end
                uars_pkg::OP_SCAN_END: r_cur <= r_idx;
                uars_pkg::OP_ROUND_END: begin
                    if (r_countdown == 8'd0) begin
                        r_listening <= 1'b1;
                        r_countdown <= w_reload;
                    end else begin
                        r_countdown <= r_countdown - 8'd1;
                    end
                end
                uars_pkg::OP_BCN_UPDATE: begin
                    r_next_hop[w_sel] <= r_hop_addr;
                    r_hops[w_sel]     <= r_hop_cnt;
                    r_miss[w_sel]     <= 3'd0;
                end
                uars_pkg::OP_BCN_INSERT: begin
                    r_anchor[w_sel]   <= r_src;
                    r_next_hop[w_sel] <= r_hop_addr;
                    r_hops[w_sel]     <= r_hop_cnt;
                    r_miss[w_sel]     <= 3'd0;
                    if (r_count < uars_pkg::COUNT_MAX) begin
                        r_count <= r_count + 4'd1;
                    end
                end
                uars_pkg::OP_EMIT_NEXT: r_res_rd <= r_res_rd + uars_pkg::RES_IDX_W'(1);
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == uars_pkg::OP_LOAD) begin
            r_kind     <= uars_pkg::t_kind'(i_kind);
            r_ok       <= i_success;
            r_src      <= i_src_addr;
            r_dist     <= i_distance;
            r_rxq      <= i_rx_quality;
            r_hop_addr <= i_nhop_addr;
            r_hop_cnt  <= i_nhop_cnt;
        end else if (i_cmd.op == uars_pkg::OP_FAIL) begin
            r_ok <= 1'b0;
        end
        if (w_push) begin
            r_res_act[r_res_cnt[uars_pkg::RES_IDX_W-1:0]]  <= w_push_act;
            r_res_addr[r_res_cnt[uars_pkg::RES_IDX_W-1:0]] <= w_push_addr;
            r_res_rng[r_res_cnt[uars_pkg::RES_IDX_W-1:0]]  <= w_push_rng;
            r_res_q[r_res_cnt[uars_pkg::RES_IDX_W-1:0]]    <= w_push_q;
        end
    end

    assign o_action         = r_res_act[r_res_rd];
    assign o_target_address = r_res_addr[r_res_rd];
    assign o_range_value    = r_res_rng[r_res_rd];
    assign o_quality        = r_res_q[r_res_rd];
    assign o_anchor_total   = r_count;
    assign o_last           = w_rd_last;

endmodule
`default_nettype wire

>>> hw/rtl/uars_ctrl.sv
`default_nettype none
module uars_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire uars_pkg::t_dp_status i_status,
    output uars_pkg::t_dp_cmd         o_cmd
);
    uars_pkg::t_state r_state, n_state;
    logic r_tick_mode, n_tick_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= uars_pkg::S_IDLE;
            r_tick_mode <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick_mode <= n_tick_mode;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_tick_mode = r_tick_mode;
        o_cmd.op    = uars_pkg::OP_NONE;
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        unique case (r_state)
            uars_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = uars_pkg::OP_LOAD;
                    n_state  = uars_pkg::S_DECODE;
                end
            end
            uars_pkg::S_DECODE: begin
                unique case (i_status.kind)
                    uars_pkg::KIND_TICK: begin
                        if (!i_status.ranging_en) begin
                            n_state = uars_pkg::S_IDLE;
                        end else begin
                            o_cmd.op    = uars_pkg::OP_IDX_CLR;
                            n_tick_mode = 1'b1;
                            n_state     = uars_pkg::S_SCAN;
                        end
                    end
                    uars_pkg::KIND_TIMEOUT: begin
                        o_cmd.op = uars_pkg::OP_STOP_PUSH;
                        n_state  = uars_pkg::S_TMO;
                    end
                    uars_pkg::KIND_RESPONSE: n_state = uars_pkg::S_RESP;
                    uars_pkg::KIND_BEACON: begin
                        if (i_status.src_zero) begin
                            n_state = uars_pkg::S_IDLE;
                        end else begin
                            o_cmd.op = uars_pkg::OP_IDX_CLR;
                            n_state  = uars_pkg::S_BMATCH;
                        end
                    end
                    default: n_state = uars_pkg::S_IDLE;
                endcase
            end
            uars_pkg::S_TMO: begin
                priority if (i_status.listening) begin
                    o_cmd.op = uars_pkg::OP_LISTEN_CLR;
                    n_state  = uars_pkg::S_EMIT;
                end else if (i_status.retry_lt) begin
                    o_cmd.op = uars_pkg::OP_RETRY;
                    n_state  = uars_pkg::S_EMIT;
                end else begin
                    o_cmd.op = uars_pkg::OP_FAIL;
                    n_state  = uars_pkg::S_RESP;
                end
            end
            uars_pkg::S_RESP: begin
                o_cmd.op    = uars_pkg::OP_RESP;
                n_tick_mode = 1'b0;
                n_state     = uars_pkg::S_SCAN;
            end
            uars_pkg::S_SCAN: begin
                priority if (i_status.idx_end) begin
                    if (r_tick_mode) begin
                        o_cmd.op = uars_pkg::OP_SCAN_EMPTY;
                        n_state  = uars_pkg::S_EMIT;
                    end else begin
                        o_cmd.op = uars_pkg::OP_SCAN_END;
                        n_state  = uars_pkg::S_ROUND;
                    end
                end else if (i_status.occupied) begin
                    o_cmd.op = uars_pkg::OP_SCAN_HIT;
                    n_state  = uars_pkg::S_EMIT;
                end else begin
                    o_cmd.op = uars_pkg::OP_SCAN_STEP;
                end
            end
            uars_pkg::S_ROUND: begin
                o_cmd.op = uars_pkg::OP_ROUND_END;
                n_state  = uars_pkg::S_EMIT;
            end
            uars_pkg::S_BMATCH: begin
                priority if (i_status.idx_end) begin
                    o_cmd.op = uars_pkg::OP_IDX_CLR;
                    n_state  = uars_pkg::S_BFREE;
                end else if (i_status.match) begin
                    o_cmd.op = uars_pkg::OP_BCN_UPDATE;
                    n_state  = uars_pkg::S_EMIT;
                end else begin
                    o_cmd.op = uars_pkg::OP_SCAN_STEP;
                end
            end
            uars_pkg::S_BFREE: begin
                // full table and unknown address: dropped without a result
                priority if (i_status.idx_end) begin
                    n_state = uars_pkg::S_IDLE;
                end else if (!i_status.occupied) begin
                    o_cmd.op = uars_pkg::OP_BCN_INSERT;
                    n_state  = uars_pkg::S_EMIT;
                end else begin
                    o_cmd.op = uars_pkg::OP_SCAN_STEP;
                end
            end
            uars_pkg::S_EMIT: begin
                if (i_status.res_empty) begin
                    n_state = uars_pkg::S_IDLE;
                end else begin
                    o_m_tvalid = 1'b1;
                    if (i_m_tready) begin
                        if (i_status.rd_last) begin
                            n_state = uars_pkg::S_IDLE;
                        end else begin
                            o_cmd.op = uars_pkg::OP_EMIT_NEXT;
                        end
                    end
                end
            end
            default: n_state = uars_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/uwb_anchor_ranging_scheduler_top.sv
`default_nettype none
// Anchor ranging scheduler. Takes radio events (tick, rx timeout, ranging
// response, beacon) one item at a time and returns zero to four command items,
// the last of each group flagged by m_axis_tlast. Each item is accepted and then
// decoded; a timeout adds the retry decision, and a response or a failed poll adds
// a step to settle the slot and another step when the round ends. The slot table
// is walked one slot a cycle; a beacon from an unknown address walks it twice
// (match, then free slot). Results go out one a cycle, held by any m_axis_tready
// stall. The longest path without stalls is a beacon inserted into the last slot
// or dropped with a full table. A new item is taken only once all results of the
// previous one have been delivered. Config writes are taken any cycle and should
// only be issued while the block is idle.
module uwb_anchor_ranging_scheduler_top #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // success, source address, distance, rx quality, next hop address,
    // hop number, zero pad
    input  wire logic [71:0] s_axis_tdata,
    // kind
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // target_address, range_value, quality, anchor_total, zero pad
    output logic [47:0]      m_axis_tdata,
    // action
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    uars_pkg::t_dp_cmd    w_cmd;
    uars_pkg::t_dp_status w_status;
    uars_pkg::t_action    w_action;
    logic [15:0] w_target;
    logic [15:0] w_range;
    logic [7:0]  w_quality;
    logic [3:0]  w_total;

    uars_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    uars_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_kind           (s_axis_tuser),
        .i_success        (s_axis_tdata[0]),
        .i_src_addr       (s_axis_tdata[16:1]),
        .i_distance       (s_axis_tdata[32:17]),
        .i_rx_quality     (s_axis_tdata[40:33]),
        .i_nhop_addr      (s_axis_tdata[56:41]),
        .i_nhop_cnt       (s_axis_tdata[64:57]),
        .o_action         (w_action),
        .o_target_address (w_target),
        .o_range_value    (w_range),
        .o_quality        (w_quality),
        .o_anchor_total   (w_total),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tuser = w_action;
    assign m_axis_tdata = {4'd0, w_total, w_quality, w_range, w_target};

    // input and output sides never open together
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while results pending");

    // anchor count never exceeds the table size
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[43:40] <= 4'(NUM_SLOTS)))
        else $error("anchor total above slot count");

    // an accepted item closes the input side for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after accept");

endmodule
`default_nettype wire

>>> tb/sv/tb_uwb_anchor_ranging_scheduler_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_uwb_anchor_ranging_scheduler_top;

    localparam int NSLOT = 8;
    localparam int WDOG_LIMIT = 20000;
    // an index past the register list, writes to it are dropped
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd5;

    typedef struct packed {
        uars_pkg::t_kind kind;
        logic        success;
        logic [15:0] src;
        logic [15:0] meas;
        logic [7:0]  q;
        logic [15:0] hop_addr;
        logic [7:0]  hop_cnt;
    } t_event;

    typedef struct packed {
        uars_pkg::t_action act;
        logic [15:0] addr;
        logic [15:0] rng;
        logic [7:0]  q;
        logic [3:0]  total;
        logic        last;
    } t_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    uwb_anchor_ranging_scheduler_top #(.NUM_SLOTS(NSLOT)) i_dut (.*);

    // predictor state
    logic        cfg_rng_en, cfg_rep_en;
    logic [7:0]  cfg_bper;
    logic [2:0]  cfg_retry, cfg_evict;
    logic [15:0] tbl_addr [NSLOT];
    logic [2:0]  tbl_miss [NSLOT];
    logic [3:0]  cur_slot;
    logic [2:0]  retries;
    logic        in_window;
    logic [7:0]  bcn_cnt;
    logic [3:0]  n_anchors;

    t_event pending_events[$];
    t_cmd   expected_cmds[$];
    t_cmd   step_cmds[$];

    int  n_err = 0;
    int  wdog = 0;
    bit  quiet = 0;

    function automatic logic [7:0] bcn_reload();
        return (cfg_bper == 0) ? 8'd0 : cfg_bper - 8'd1;
    endfunction

    function automatic logic [3:0] next_occupied(logic [3:0] s);
        while (s < NSLOT && tbl_addr[s] == 16'd0) s++;
        return s;
    endfunction

    function automatic void push_cmd(uars_pkg::t_action a, logic [15:0] ad,
                                     logic [15:0] r, logic [7:0] qq);
        t_cmd c;
        c = '{act: a, addr: ad, rng: r, q: qq, total: 4'd0, last: 1'b0};
        step_cmds.push_back(c);
    endfunction

    function automatic void close_round(bit ok, logic [15:0] src, logic [15:0] meas,
                                        logic [7:0] qq);
        logic [3:0] s;
        s = cur_slot;
        if (s < NSLOT) begin
            if (!ok) begin
                if (tbl_miss[s] < 3'd7) tbl_miss[s]++;
                if (tbl_miss[s] > cfg_evict && tbl_addr[s] != 0) begin
                    tbl_addr[s] = 0;
                    if (n_anchors > 0) n_anchors--;
                    push_cmd(uars_pkg::ACT_LIST, 0, 0, 0);
                end
            end else begin
                tbl_miss[s] = 0;
            end
        end
        if (cfg_rep_en && ok) push_cmd(uars_pkg::ACT_REPORT, src, meas, qq);
        cur_slot = next_occupied(s < NSLOT ? s + 4'd1 : 4'(NSLOT));
        if (cur_slot < NSLOT) begin
            push_cmd(uars_pkg::ACT_POLL, tbl_addr[cur_slot], 0, 0);
        end else begin
            push_cmd(uars_pkg::ACT_DONE, 0, 0, 0);
            if (bcn_cnt == 0) begin
                push_cmd(uars_pkg::ACT_LISTEN, 0, 0, 0);
                in_window = 1;
                bcn_cnt = bcn_reload();
            end else begin
                bcn_cnt--;
                push_cmd(uars_pkg::ACT_STOP, 0, 0, 0);
            end
        end
    endfunction

    function automatic void predict_event(t_event e);
        int i;
        bit done;
        step_cmds.delete();
        done = 0;
        case (e.kind)
            uars_pkg::KIND_TICK: begin
                if (cfg_rng_en) begin
                    cur_slot = next_occupied(0);
                    if (cur_slot >= NSLOT) begin
                        push_cmd(uars_pkg::ACT_LISTEN, 0, 0, 0);
                        in_window = 1;
                    end else begin
                        push_cmd(uars_pkg::ACT_POLL, tbl_addr[cur_slot], 0, 0);
                    end
                end
            end
            uars_pkg::KIND_TIMEOUT: begin
                push_cmd(uars_pkg::ACT_STOP, 0, 0, 0);
                if (in_window) begin
                    in_window = 0;
                end else if (retries < cfg_retry) begin
                    retries++;
                    push_cmd(uars_pkg::ACT_POLL,
                             cur_slot < NSLOT ? tbl_addr[cur_slot] : 16'd0, 0, 0);
                end else begin
                    retries = 0;
                    close_round(0, 0, 0, 0);
                end
            end
            uars_pkg::KIND_RESPONSE: close_round(e.success, e.src, e.meas, e.q);
            default: begin
                if (e.src != 0) begin
                    for (i = 0; i < NSLOT; i++)
                        if (!done && tbl_addr[i] == e.src) begin
                            tbl_miss[i] = 0;
                            done = 1;
                        end
                    for (i = 0; i < NSLOT; i++)
                        if (!done && tbl_addr[i] == 0) begin
                            tbl_addr[i] = e.src;
                            tbl_miss[i] = 0;
                            if (n_anchors < 15) n_anchors++;
                            push_cmd(uars_pkg::ACT_LIST, 0, 0, 0);
                            done = 1;
                        end
                end
            end
        endcase
        for (i = 0; i < step_cmds.size(); i++) begin
            step_cmds[i].total = n_anchors;
            step_cmds[i].last = (i == step_cmds.size() - 1);
            expected_cmds.push_back(step_cmds[i]);
        end
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    int s_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_event(pending_events.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    t_event e;
                    e = pending_events[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= e.kind;
                    s_axis_tdata <= {7'd0, e.hop_cnt, e.hop_addr, e.q, e.meas, e.src,
                                     e.success};
                    if (!quiet && $urandom_range(0, 5) == 0)
                        s_gap <= $urandom_range(1, 17);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_cmd got, want;
                got = '{act: uars_pkg::t_action'(m_axis_tuser), addr: m_axis_tdata[15:0],
                        rng: m_axis_tdata[31:16], q: m_axis_tdata[39:32],
                        total: m_axis_tdata[43:40], last: m_axis_tlast};
                if (expected_cmds.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result item %h", got);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: expected act=%0d addr=%h rng=%h q=%h ",
                                     want.act, want.addr, want.rng, want.q,
                                     "tot=%0d last=%b, got act=%0d addr=%h rng=%h ",
                                     want.total, want.last, got.act, got.addr, got.rng,
                                     "q=%h tot=%0d last=%b", got.q, got.total, got.last);
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) m_gap <= $urandom_range(1, 17);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_event rand_event(uars_pkg::t_kind k);
        t_event e;
        e.kind = k;
        e.success = $urandom_range(0, 3) != 0;
        e.src = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        e.meas = 16'($urandom);
        e.q = 8'($urandom);
        e.hop_addr = 16'($urandom);
        e.hop_cnt = 8'($urandom);
        return e;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            uars_pkg::CFG_RANGING_EN:  cfg_rng_en = val[0];
            uars_pkg::CFG_REPORT_EN:   cfg_rep_en = val[0];
            uars_pkg::CFG_BEACON_PER:  cfg_bper = val;
            uars_pkg::CFG_RETRY_LIMIT: cfg_retry = val[2:0];
            uars_pkg::CFG_EVICT_THR:   cfg_evict = val[2:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_events.size() > 0 || s_axis_tvalid || expected_cmds.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // random mix of ticks, timeouts, responses and beacons
    task automatic queue_phase(int n);
        int i;
        uars_pkg::t_kind k;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    k = uars_pkg::KIND_TICK;
                2, 3:    k = uars_pkg::KIND_TIMEOUT;
                4, 5, 6: k = uars_pkg::KIND_RESPONSE;
                default: k = uars_pkg::KIND_BEACON;
            endcase
            pending_events.push_back(rand_event(k));
        end
    endtask

    initial begin
        t_event e;
        int i, ph;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_addr = 0;
        i_cfg_wdata = 0;
        cfg_rng_en = 0; cfg_rep_en = 1; cfg_bper = 4; cfg_retry = 4; cfg_evict = 3;
        for (i = 0; i < NSLOT; i++) begin
            tbl_addr[i] = 0;
            tbl_miss[i] = 0;
        end
        cur_slot = 0; retries = 0; in_window = 0; bcn_cnt = 3; n_anchors = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tick while disabled, beacon from zero, empty-table paths
        pending_events.push_back(rand_event(uars_pkg::KIND_TICK));
        e = rand_event(uars_pkg::KIND_BEACON); e.src = 0; pending_events.push_back(e);
        e = rand_event(uars_pkg::KIND_TIMEOUT); pending_events.push_back(e);
        e = rand_event(uars_pkg::KIND_RESPONSE); e.src = 16'hFFFF; e.meas = 16'hFFFF;
        e.q = 8'hFF; e.success = 1; pending_events.push_back(e);
        drain();
        cfg_write(uars_pkg::CFG_RANGING_EN, 1);
        cfg_write(CFG_UNUSED_IDX, 8'hFF);
        pending_events.push_back(rand_event(uars_pkg::KIND_TICK));
        pending_events.push_back(rand_event(uars_pkg::KIND_TIMEOUT));
        // fill table past full
        for (i = 1; i <= 9; i++) begin
            e = rand_event(uars_pkg::KIND_BEACON);
            e.src = (i == 9) ? 16'hFFFF : 16'(i);
            e.hop_addr = (i[0]) ? 16'hFFFF : 16'h0;
            e.hop_cnt = (i[0]) ? 8'hFF : 8'h0;
            pending_events.push_back(e);
        end
        e = rand_event(uars_pkg::KIND_BEACON); e.src = 3; pending_events.push_back(e);
        pending_events.push_back(rand_event(uars_pkg::KIND_TICK));
        for (i = 0; i < 6; i++) pending_events.push_back(rand_event(uars_pkg::KIND_TIMEOUT));
        e = rand_event(uars_pkg::KIND_RESPONSE); e.success = 0; e.meas = 0; e.q = 0;
        e.src = 0;
        pending_events.push_back(e);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    cfg_write(uars_pkg::CFG_RETRY_LIMIT, 0);
                    cfg_write(uars_pkg::CFG_EVICT_THR, 0);
                    cfg_write(uars_pkg::CFG_BEACON_PER, 1);
                end
                1: begin
                    cfg_write(uars_pkg::CFG_RETRY_LIMIT, 7);
                    cfg_write(uars_pkg::CFG_EVICT_THR, 7);
                    cfg_write(uars_pkg::CFG_BEACON_PER, 255);
                    cfg_write(uars_pkg::CFG_REPORT_EN, 0);
                end
                2: begin
                    cfg_write(uars_pkg::CFG_BEACON_PER, 0);
                    cfg_write(uars_pkg::CFG_REPORT_EN, 1);
                    cfg_write(uars_pkg::CFG_EVICT_THR, 6);
                end
                3: cfg_write(uars_pkg::CFG_RANGING_EN, 0);
                default: begin
                    cfg_write(uars_pkg::CFG_RANGING_EN, 1);
                    cfg_write(uars_pkg::CFG_RETRY_LIMIT, 8'($urandom_range(0, 7)));
                    cfg_write(uars_pkg::CFG_EVICT_THR, 8'($urandom_range(0, 7)));
                    cfg_write(uars_pkg::CFG_BEACON_PER, 8'($urandom_range(1, 5)));
                    cfg_write(uars_pkg::CFG_REPORT_EN, 8'($urandom_range(0, 1)));
                end
            endcase
            if (ph == 7) quiet = 1;
            queue_phase(48);
            drain();
        end

        if (n_err == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> uwb_anchor_ranging_scheduler_top.f
hw/rtl/uars_pkg.sv
hw/rtl/uars_dp.sv
hw/rtl/uars_ctrl.sv
hw/rtl/uwb_anchor_ranging_scheduler_top.sv
tb/sv/tb_uwb_anchor_ranging_scheduler_top.sv
